/* hw/rtl/dnv_pkg.sv */
// ----------------------------------------------------------------------------
// dnv_pkg
// Shared types, constants and character classes for the bus name validator.
// ----------------------------------------------------------------------------
`default_nettype none

package dnv_pkg;

  // Longest member or interface name accepted
  localparam int unsigned MAX_NAME_LEN_DEF = 255;

  // Check mode register codes
  typedef enum logic [1:0] {
    MODE_PATH   = 2'd0,
    MODE_MEMBER = 2'd1,
    MODE_IFACE  = 2'd2
  } mode_t;

  // Character codes with a role of their own
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Letter, digit or underscore
  function automatic logic is_name_char(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) ||
           is_digit(c) || (c == CH_USCORE);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/dbus_name_validator_top.sv */
// ----------------------------------------------------------------------------
// dbus_name_validator_top
// Streaming checker for object paths, member names and interface names.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes of a name arrive on the in_ channel (in_valid / in_stall / in_ch),
//   one byte per transfer; a zero byte ends the string. Each terminator gives
//   one verdict transfer on the out_ channel (out_valid / out_stall /
//   out_valid_res); other bytes give none. cfg_we with cfg_wdata selects the
//   mode (0 object path, 1 member name, 2 interface name); the user must keep
//   it written only while the block is idle; the block does not enforce this.
//   A terminator passes the input register (s1) and then the verdict register
//   (out_valid_r / out_res_r). Throughput: one byte per cycle while in_stall is
//   low, set by the single input register feeding the per-string flag and
//   counter update. Reset clears the per-string state, the valid flags of both
//   pipeline registers and the mode (object path). While a verdict waits under
//   out_stall, non-terminator bytes keep flowing; a second terminator holds in
//   the input register and in_stall rises until the waiting verdict is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dbus_name_validator_top
  import dnv_pkg::*;
#(
  parameter int unsigned MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // byte input
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_ch,
  // verdict output
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_valid_res,
  // mode register
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata
);

  localparam int unsigned CW = $clog2(MAX_NAME_LEN + 2);
  localparam logic [CW-1:0] CNT_SAT = CW'(MAX_NAME_LEN + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_NAME_LEN);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  mode_t           mode_r;
  logic            s1_valid_r, s1_valid_nxt;
  logic [7:0]      s1_ch_r;
  logic            out_valid_r, out_valid_nxt;
  logic            out_res_r, out_res_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            elem_empty_r, elem_empty_nxt;
  logic            err_r, err_nxt;
  logic            dot_r, dot_nxt;

  logic            s1_nul;
  logic            out_free;
  logic            s1_adv;
  logic            in_xfer;
  logic            len_ok;
  logic            verdict;
  logic            first;

  // Handshake control
  assign s1_nul   = (s1_ch_r == CH_NUL);
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_nul || out_free;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;

  assign first  = (count_r == '0);
  assign len_ok = (count_r >= CNT_ONE) && (count_r <= CNT_MAX);

  // Verdict for a terminator under the current mode
  always_comb begin
    case (mode_r)
      MODE_PATH:   verdict = !err_r && !first && ((count_r == CNT_ONE) || !elem_empty_r);
      MODE_MEMBER: verdict = !err_r && len_ok;
      MODE_IFACE:  verdict = !err_r && len_ok && dot_r && !elem_empty_r;
      default:     verdict = 1'b0;
    endcase
  end

  // Per-string state update and pipeline next values
  always_comb begin
    s1_valid_nxt   = s1_valid_r;
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    count_nxt      = count_r;
    elem_empty_nxt = elem_empty_r;
    err_nxt        = err_r;
    dot_nxt        = dot_r;

    // drop a verdict once it is taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (s1_valid_r && s1_adv) begin
      if (s1_nul) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = verdict;
        count_nxt      = '0;
        elem_empty_nxt = 1'b1;
        err_nxt        = 1'b0;
        dot_nxt        = 1'b0;
      end else begin
        case (mode_r)
          MODE_PATH: begin
            if (first && (s1_ch_r != CH_SLASH)) begin
              err_nxt = 1'b1;
            end
            if (s1_ch_r == CH_SLASH) begin
              if (elem_empty_r && !first) begin
                err_nxt = 1'b1;
              end
              elem_empty_nxt = 1'b1;
            end else if (is_name_char(s1_ch_r)) begin
              elem_empty_nxt = 1'b0;
            end else begin
              err_nxt = 1'b1;
            end
          end
          MODE_MEMBER: begin
            if (!is_name_char(s1_ch_r) || (first && is_digit(s1_ch_r))) begin
              err_nxt = 1'b1;
            end
            elem_empty_nxt = 1'b0;
          end
          MODE_IFACE: begin
            if (s1_ch_r == CH_DOT) begin
              if (elem_empty_r) begin
                err_nxt = 1'b1;
              end
              dot_nxt        = 1'b1;
              elem_empty_nxt = 1'b1;
            end else if (is_name_char(s1_ch_r)) begin
              if (elem_empty_r && is_digit(s1_ch_r)) begin
                err_nxt = 1'b1;
              end
              elem_empty_nxt = 1'b0;
            end else begin
              err_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
        // saturate the length one past the limit
        if (count_r < CNT_SAT) begin
          count_nxt = count_r + CNT_ONE;
        end
      end
    end

    // advance the input register
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_PATH;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      count_r      <= '0;
      elem_empty_r <= 1'b1;
      err_r        <= 1'b0;
      dot_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= mode_t'(cfg_wdata);
      end
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      count_r      <= count_nxt;
      elem_empty_r <= elem_empty_nxt;
      err_r        <= err_nxt;
      dot_r        <= dot_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ch_r <= in_ch;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = out_res_r;

endmodule

`default_nettype wire

/* hw/rtl/dnv_checker.sv */
// ----------------------------------------------------------------------------
// dnv_checker
// Port-level assertions for the bus name validator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dnv_checker
  import dnv_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] in_ch,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_valid_res
);

  // Hold a stalled verdict
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_valid_res))
    else $error("stalled verdict changed or vanished");

  // Reset leaves no verdict pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("verdict pending after reset");

  // Input back-pressure only while a verdict waits under stall
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting verdict");

  // A fresh verdict follows a terminator transfer through the input register
  a_verdict_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && (in_ch == CH_NUL), 2))
    else $error("verdict without a terminator transfer");

endmodule

bind dbus_name_validator_top dnv_checker u_dnv_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_ch        (in_ch),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_valid_res(out_valid_res)
);

`default_nettype wire
